// ===== design/bbd_pkg.sv =====
// Shared types and constants for the Bayer bilinear demosaic block.
package bbd_pkg;

   // Pixel and register field widths.
   localparam int PIX_W         = 8;
   localparam int CFG_WIDTH_W   = 13;
   localparam int ROW_W         = 16;
   localparam int CSR_DATA_W    = 16;
   localparam int CSR_INDEX_W   = 1;
   localparam int LS_DATA_W     = 2 * PIX_W;

   // Default for the largest supported row length.
   localparam int MAX_WIDTH_DEFAULT = 4096;

   // Register reset values and the smallest legal frame dimension.
   localparam int FRAME_WIDTH_RESET  = 640;
   localparam int FRAME_HEIGHT_RESET = 480;
   localparam int MIN_FRAME_DIM      = 2;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   // Neighborhood flags for the pixel being interpolated.
   typedef struct packed {
      logic up;
      logic dn;
      logic lf;
      logic rt;
      logic odd_row;
      logic odd_col;
   } nbr_type;

endpackage

// ===== design/bbd_line_store.sv =====
// Two-row line memory, one entry per column holding the two previous rows.
module bbd_line_store #(
   parameter int DEPTH = bbd_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           rd_en,
   input  logic [$clog2(DEPTH)-1:0]       rd_addr,
   output logic [bbd_pkg::LS_DATA_W-1:0]  rd_data,
   input  logic                           wr_en,
   input  logic [$clog2(DEPTH)-1:0]       wr_addr,
   input  logic [bbd_pkg::LS_DATA_W-1:0]  wr_data
);

   logic [bbd_pkg::LS_DATA_W-1:0] mem [DEPTH];
   logic [bbd_pkg::LS_DATA_W-1:0] rd_data_ff;

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/bbd_interp.sv =====
// 3x3 window registers and the bilinear color interpolation.
module bbd_interp (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        shift_en,
   input  logic [bbd_pkg::PIX_W-1:0]   col_top,
   input  logic [bbd_pkg::PIX_W-1:0]   col_mid,
   input  logic [bbd_pkg::PIX_W-1:0]   col_pix,
   input  bbd_pkg::nbr_type            nbr,
   output logic [bbd_pkg::PIX_W-1:0]   red,
   output logic [bbd_pkg::PIX_W-1:0]   green,
   output logic [bbd_pkg::PIX_W-1:0]   blue
);

   localparam int SUM_W      = 10;
   localparam int CNT_W      = 3;
   localparam int PROD_W     = 20;
   localparam int RECIP3     = 683;
   localparam int RECIP3_SH  = 11;

   logic [bbd_pkg::PIX_W-1:0] win_ff [9];
   logic [bbd_pkg::PIX_W-1:0] win_in [9];

   logic [SUM_W-1:0] hs, vs, ds;
   logic [CNT_W-1:0] hn, vn, dnum;
   logic [bbd_pkg::PIX_W-1:0] ctr, avg_h, avg_v, avg_d, avg_c;

   // Truncated mean of up to four samples; a division by three uses a reciprocal.
   function automatic logic [bbd_pkg::PIX_W-1:0] mean(input logic [SUM_W-1:0] sum,
                                                      input logic [CNT_W-1:0] count);
      logic [PROD_W-1:0] prod;
      logic [bbd_pkg::PIX_W-1:0] res;
      prod = PROD_W'(sum) * PROD_W'(RECIP3);
      case (count)
         3'd1:    res = sum[bbd_pkg::PIX_W-1:0];
         3'd2:    res = sum[bbd_pkg::PIX_W:1];
         3'd3:    res = prod[RECIP3_SH+bbd_pkg::PIX_W-1:RECIP3_SH];
         3'd4:    res = sum[bbd_pkg::PIX_W+1:2];
         default: res = '0;
      endcase
      return res;
   endfunction

   // The window shifts left by one column; the new column enters on the right.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         win_in[k*3]     = win_ff[k*3+1];
         win_in[k*3 + 1] = win_ff[k*3+2];
      end
      win_in[2] = col_top;
      win_in[5] = col_mid;
      win_in[8] = col_pix;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else if (shift_en) begin
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
   end

   // Neighbor sums and counts; samples outside the frame are dropped.
   always_comb begin
      ctr  = win_in[4];
      hs   = (nbr.lf ? SUM_W'(win_in[3]) : '0) + (nbr.rt ? SUM_W'(win_in[5]) : '0);
      hn   = CNT_W'(nbr.lf) + CNT_W'(nbr.rt);
      vs   = (nbr.up ? SUM_W'(win_in[1]) : '0) + (nbr.dn ? SUM_W'(win_in[7]) : '0);
      vn   = CNT_W'(nbr.up) + CNT_W'(nbr.dn);
      ds   = ((nbr.up && nbr.lf) ? SUM_W'(win_in[0]) : '0)
           + ((nbr.up && nbr.rt) ? SUM_W'(win_in[2]) : '0)
           + ((nbr.dn && nbr.lf) ? SUM_W'(win_in[6]) : '0)
           + ((nbr.dn && nbr.rt) ? SUM_W'(win_in[8]) : '0);
      dnum = CNT_W'(nbr.up && nbr.lf) + CNT_W'(nbr.up && nbr.rt)
           + CNT_W'(nbr.dn && nbr.lf) + CNT_W'(nbr.dn && nbr.rt);
      avg_h = mean(hs, hn);
      avg_v = mean(vs, vn);
      avg_d = mean(ds, dnum);
      avg_c = mean(hs + vs, hn + vn);
   end

   // Pick the channels by site color of the GBRG pattern.
   always_comb begin
      if (!nbr.odd_row && !nbr.odd_col) begin
         green = ctr;   blue = avg_h; red = avg_v;
      end else if (!nbr.odd_row) begin
         blue = ctr;    green = avg_c; red = avg_d;
      end else if (!nbr.odd_col) begin
         red = ctr;     green = avg_c; blue = avg_d;
      end else begin
         green = ctr;   red = avg_h;  blue = avg_v;
      end
   end

endmodule

// ===== design/bayer_bilinear_demosaic_top.sv =====
// Bilinear GBRG Bayer demosaic: stream control, line memory and output register.
// A pixel's RGB result is presented from the output register once the transaction
// that completes its 3x3 neighborhood, frame_width+1 transactions after its own, has
// passed stage one. Throughput: one transaction per cycle unless the output stalls,
// set by one line memory read and write-back per column. Reset: counters cleared,
// width 640, height 480; the line memory is not cleared and needs no clearing pass.
module bayer_bilinear_demosaic_top #(
   parameter int MAX_WIDTH = bbd_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [bbd_pkg::PIX_W-1:0]         req_raw_pixel,
   input  logic                              req_flush,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [bbd_pkg::PIX_W-1:0]         rsp_red,
   output logic [bbd_pkg::PIX_W-1:0]         rsp_green,
   output logic [bbd_pkg::PIX_W-1:0]         rsp_blue,
   output logic                              rsp_end_of_frame,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bbd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bbd_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int WID_W  = $clog2(MAX_WIDTH + 1);
   localparam int CNT_W  = COL_W + 1;
   localparam int ROWC_W = bbd_pkg::ROW_W + 1;
   localparam int RESET_WIDTH = (bbd_pkg::FRAME_WIDTH_RESET > MAX_WIDTH) ?
                                MAX_WIDTH : bbd_pkg::FRAME_WIDTH_RESET;

   // Effective frame size registers.
   logic [WID_W-1:0]           eff_width_ff, eff_width_in;
   logic [bbd_pkg::ROW_W-1:0]  eff_height_ff, eff_height_in;
   logic [bbd_pkg::CFG_WIDTH_W-1:0] cfg_width;
   logic                       csr_write;

   // Position counters.
   logic [COL_W-1:0]           in_col_ff, in_col_in;
   logic [ROWC_W-1:0]          in_row_ff, in_row_in;
   logic [COL_W-1:0]           out_col_ff, out_col_in;
   logic [bbd_pkg::ROW_W-1:0]  out_row_ff, out_row_in;

   // Stage one: item waiting for its line memory data.
   logic                       s1_valid_ff, s1_valid_in;
   logic                       s1_emit_ff;
   logic [bbd_pkg::PIX_W-1:0]  s1_pix_ff;
   logic [COL_W-1:0]           s1_col_ff;
   logic                       s1_go;

   // Output register.
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [bbd_pkg::PIX_W-1:0]  rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic                       rsp_eof_ff;

   logic [CNT_W-1:0]           width_cnt, in_col_next, out_col_next;
   logic [ROWC_W-1:0]          height_ext;
   logic                       in_frame, at_restart, emit, accept, keep, in_wrap;
   logic                       last;
   bbd_pkg::nbr_type           nbr;
   logic [bbd_pkg::LS_DATA_W-1:0] ls_rd_data, ls_col, ls_wr_data, fwd_data_ff;
   logic                       fwd_ff;
   logic [bbd_pkg::PIX_W-1:0]  int_red, int_green, int_blue;

   // Configuration writes are always taken; values are clamped on the way in.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign cfg_width = csr_wdata[bbd_pkg::CFG_WIDTH_W-1:0];

   always_comb begin
      eff_width_in  = eff_width_ff;
      eff_height_in = eff_height_ff;
      if (csr_write) begin
         unique case (csr_index)
            bbd_pkg::CSR_FRAME_WIDTH: begin
               if (cfg_width < bbd_pkg::CFG_WIDTH_W'(bbd_pkg::MIN_FRAME_DIM)) begin
                  eff_width_in = WID_W'(bbd_pkg::MIN_FRAME_DIM);
               end else if (32'(cfg_width) > MAX_WIDTH) begin
                  eff_width_in = WID_W'(MAX_WIDTH);
               end else begin
                  eff_width_in = WID_W'(cfg_width);
               end
            end
            bbd_pkg::CSR_FRAME_HEIGHT: begin
               if (csr_wdata < bbd_pkg::ROW_W'(bbd_pkg::MIN_FRAME_DIM)) begin
                  eff_height_in = bbd_pkg::ROW_W'(bbd_pkg::MIN_FRAME_DIM);
               end else begin
                  eff_height_in = csr_wdata[bbd_pkg::ROW_W-1:0];
               end
            end
            default: begin
               eff_width_in  = eff_width_ff;
               eff_height_in = eff_height_ff;
            end
         endcase
      end
   end

   // Input side: frame position of the incoming transaction.
   assign width_cnt   = CNT_W'(eff_width_ff);
   assign height_ext  = ROWC_W'(eff_height_ff);
   assign in_col_next = CNT_W'(in_col_ff) + CNT_W'(1);
   assign in_wrap     = in_col_next >= width_cnt;
   assign in_frame    = in_row_ff < height_ext;
   assign at_restart  = (in_row_ff == ROWC_W'(height_ext + ROWC_W'(1))) && (in_col_ff == '0);
   assign emit        = !((in_row_ff == '0) || ((in_row_ff == ROWC_W'(1)) && (in_col_ff == '0)));

   // A flush inside the frame is taken and dropped without touching any state.
   assign s1_go     = s1_valid_ff && (!s1_emit_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_go;
   assign accept    = req_valid && req_ready;
   assign keep      = accept && !(in_frame && req_flush);

   always_comb begin
      in_col_in = in_col_ff;
      in_row_in = in_row_ff;
      if (csr_write) begin
         in_col_in = '0;
         in_row_in = '0;
      end else if (keep) begin
         if (at_restart) begin
            in_col_in = '0;
            in_row_in = '0;
         end else if (in_wrap) begin
            in_col_in = '0;
            in_row_in = in_row_ff + ROWC_W'(1);
         end else begin
            in_col_in = in_col_next[COL_W-1:0];
         end
      end
   end

   // A read of the column that is written back at the same edge takes the new data.
   assign ls_col     = fwd_ff ? fwd_data_ff : ls_rd_data;
   assign ls_wr_data = {ls_col[bbd_pkg::PIX_W-1:0], s1_pix_ff};

   // Line memory: read at acceptance, write the shifted column back when stage one moves on.
   bbd_line_store #(
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (keep),
      .rd_addr (in_col_ff),
      .rd_data (ls_rd_data),
      .wr_en   (s1_go),
      .wr_addr (s1_col_ff),
      .wr_data (ls_wr_data)
   );

   // Stage one occupancy.
   always_comb begin
      if (keep) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   // Output position and neighbor availability.
   assign out_col_next = CNT_W'(out_col_ff) + CNT_W'(1);
   always_comb begin
      nbr.up      = out_row_ff != '0;
      nbr.dn      = (ROWC_W'(out_row_ff) + ROWC_W'(1)) < height_ext;
      nbr.lf      = out_col_ff != '0;
      nbr.rt      = out_col_next < width_cnt;
      nbr.odd_row = out_row_ff[0];
      nbr.odd_col = out_col_ff[0];
   end
   assign last = !nbr.dn && !nbr.rt;

   always_comb begin
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (csr_write) begin
         out_col_in = '0;
         out_row_in = '0;
      end else if (s1_go && s1_emit_ff) begin
         if (last) begin
            out_col_in = '0;
            out_row_in = '0;
         end else if (!nbr.rt) begin
            out_col_in = '0;
            out_row_in = out_row_ff + bbd_pkg::ROW_W'(1);
         end else begin
            out_col_in = out_col_next[COL_W-1:0];
         end
      end
   end

   // Window and interpolation.
   bbd_interp u_interp (
      .clock    (clock),
      .reset    (reset),
      .shift_en (s1_go),
      .col_top  (ls_col[bbd_pkg::LS_DATA_W-1:bbd_pkg::PIX_W]),
      .col_mid  (ls_col[bbd_pkg::PIX_W-1:0]),
      .col_pix  (s1_pix_ff),
      .nbr      (nbr),
      .red      (int_red),
      .green    (int_green),
      .blue     (int_blue)
   );

   // Output register occupancy.
   always_comb begin
      if (s1_go && s1_emit_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         eff_width_ff  <= WID_W'(RESET_WIDTH);
         eff_height_ff <= bbd_pkg::ROW_W'(bbd_pkg::FRAME_HEIGHT_RESET);
         in_col_ff     <= '0;
         in_row_ff     <= '0;
         out_col_ff    <= '0;
         out_row_ff    <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         eff_width_ff  <= eff_width_in;
         eff_height_ff <= eff_height_in;
         in_col_ff     <= in_col_in;
         in_row_ff     <= in_row_in;
         out_col_ff    <= out_col_in;
         out_row_ff    <= out_row_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (keep) begin
         s1_emit_ff  <= emit;
         s1_pix_ff   <= in_frame ? req_raw_pixel : '0;
         s1_col_ff   <= in_col_ff;
         fwd_ff      <= s1_go && (in_col_ff == s1_col_ff);
         fwd_data_ff <= ls_wr_data;
      end
      if (s1_go && s1_emit_ff) begin
         rsp_red_ff   <= int_red;
         rsp_green_ff <= int_green;
         rsp_blue_ff  <= int_blue;
         rsp_eof_ff   <= last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_red          = rsp_red_ff;
   assign rsp_green        = rsp_green_ff;
   assign rsp_blue         = rsp_blue_ff;
   assign rsp_end_of_frame = rsp_eof_ff;

   // Read and write-back of the same column only meet when a frame starts over.
   a_rw_collision_at_restart: assert property (@(posedge clock) disable iff (reset)
      !(keep && s1_go && (in_col_ff == s1_col_ff)) || (in_col_ff == '0))
      else $error("line memory read and write-back meet away from column zero");

   // After the last pixel of a frame the output position starts over.
   a_restart_after_last: assert property (@(posedge clock) disable iff (reset)
      (s1_go && s1_emit_ff && last && !csr_write) |=> (out_col_ff == '0) && (out_row_ff == '0))
      else $error("output position not cleared after end of frame");

   // The input row never runs more than two rows past the last row of the frame.
   a_in_row_bound: assert property (@(posedge clock) disable iff (reset)
      in_row_ff <= ROWC_W'(height_ext + ROWC_W'(1)))
      else $error("input row counter ran past the frame tail");

   // The output column stays inside the row.
   a_out_col_bound: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(out_col_ff) < width_cnt)
      else $error("output column outside the frame");

endmodule

// ===== dv/bayer_bilinear_demosaic_top_tb.sv =====
// Self-checking testbench for the GBRG bilinear demosaic block.
`timescale 1ns / 100ps

module bayer_bilinear_demosaic_top_tb;
   import bbd_pkg::*;

   localparam int MAX_W         = MAX_WIDTH_DEFAULT;
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_HOLD     = 300;
   localparam int RANDOM_ITEMS  = 100;
   localparam int QUIET_ITEMS   = 50;

   // One demosaiced output pixel.
   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic             eof;
   } rgb_pixel_type;

   // How the pixels of a frame are filled.
   typedef enum logic [1:0] {FILL_RANDOM, FILL_ZERO, FILL_MAX, FILL_CHECKER} fill_kind_type;

   // Tracks the demosaic state and keeps the RGB pixels still owed by the block.
   class demosaic_predictor;
      logic [CFG_WIDTH_W-1:0] width_reg;
      logic [ROW_W-1:0]       height_reg;
      logic [PIX_W-1:0]       row_older [MAX_W];
      logic [PIX_W-1:0]       row_newer [MAX_W];
      int unsigned            nbhd [9];
      int unsigned            in_col, in_row, out_col, out_row;
      rgb_pixel_type          pending_rgb [$];
      int unsigned            mismatch_count;

      function new();
         width_reg      = FRAME_WIDTH_RESET;
         height_reg     = FRAME_HEIGHT_RESET;
         mismatch_count = 0;
         foreach (row_older[i]) row_older[i] = '0;
         foreach (row_newer[i]) row_newer[i] = '0;
         foreach (nbhd[i]) nbhd[i] = 0;
         restart_frame();
      endfunction

      function void restart_frame();
         in_col  = 0;
         in_row  = 0;
         out_col = 0;
         out_row = 0;
      endfunction

      // Width is limited to the legal range, height only from below.
      function int unsigned clamp_width(input logic [CFG_WIDTH_W-1:0] value);
         if (value < MIN_FRAME_DIM) return MIN_FRAME_DIM;
         if (value > MAX_W) return MAX_W;
         return value;
      endfunction

      function int unsigned clamp_height(input logic [ROW_W-1:0] value);
         return (value < MIN_FRAME_DIM) ? MIN_FRAME_DIM : value;
      endfunction

      function int unsigned trunc_mean(input int unsigned sum, input int unsigned count);
         return (count != 0) ? sum / count : 0;
      endfunction

      // Any register write restarts the frame.
      function void write_register(input logic [CSR_INDEX_W-1:0] index,
                                   input logic [CSR_DATA_W-1:0] data);
         if (index == CSR_FRAME_WIDTH) begin
            width_reg = data[CFG_WIDTH_W-1:0];
         end else begin
            height_reg = data;
         end
         restart_frame();
      endfunction

      // Notes one accepted input transaction and queues the pixel it completes.
      function void take_sample(input logic [PIX_W-1:0] pixel, input logic flush);
         int unsigned     w, h, col, k, c, hs, hn, vs, vn, ds, dnum, r, g, b;
         logic [PIX_W-1:0] sample, top, mid;
         longint unsigned pos;
         bit              up, dn, lf, rt, odd_row, odd_col;
         rgb_pixel_type   pix_out;

         w = clamp_width(width_reg);
         h = clamp_height(height_reg);

         // A flush inside the frame changes nothing; after it, pixels act as flushes.
         if (in_row < h && flush) return;
         sample = (in_row < h) ? pixel : '0;

         // Line memory rotate and 3x3 window shift.
         col = in_col % MAX_W;
         top = row_older[col];
         mid = row_newer[col];
         row_older[col] = mid;
         row_newer[col] = sample;
         for (k = 0; k < 3; k++) begin
            nbhd[k*3]   = nbhd[k*3+1];
            nbhd[k*3+1] = nbhd[k*3+2];
         end
         nbhd[2] = top;
         nbhd[5] = mid;
         nbhd[8] = sample;

         pos = longint'(in_row) * w + in_col;
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
         end
         if (pos < longint'(w) + 1) return;

         // Neighbors outside the frame drop out of every average.
         up      = out_row > 0;
         dn      = out_row + 1 < h;
         lf      = out_col > 0;
         rt      = out_col + 1 < w;
         odd_row = out_row[0];
         odd_col = out_col[0];
         c    = nbhd[4];
         hs   = (lf ? nbhd[3] : 0) + (rt ? nbhd[5] : 0);
         hn   = int'(lf) + int'(rt);
         vs   = (up ? nbhd[1] : 0) + (dn ? nbhd[7] : 0);
         vn   = int'(up) + int'(dn);
         ds   = ((up && lf) ? nbhd[0] : 0) + ((up && rt) ? nbhd[2] : 0)
              + ((dn && lf) ? nbhd[6] : 0) + ((dn && rt) ? nbhd[8] : 0);
         dnum = int'(up && lf) + int'(up && rt) + int'(dn && lf) + int'(dn && rt);

         if (!odd_row && !odd_col) begin
            // Green on a blue row.
            g = c;
            b = trunc_mean(hs, hn);
            r = trunc_mean(vs, vn);
         end else if (!odd_row) begin
            // Blue site.
            b = c;
            g = trunc_mean(hs + vs, hn + vn);
            r = trunc_mean(ds, dnum);
         end else if (!odd_col) begin
            // Red site.
            r = c;
            g = trunc_mean(hs + vs, hn + vn);
            b = trunc_mean(ds, dnum);
         end else begin
            // Green on a red row.
            g = c;
            r = trunc_mean(hs, hn);
            b = trunc_mean(vs, vn);
         end

         pix_out.red   = r[PIX_W-1:0];
         pix_out.green = g[PIX_W-1:0];
         pix_out.blue  = b[PIX_W-1:0];
         pix_out.eof   = (out_row + 1 >= h) && (out_col + 1 >= w);
         pending_rgb.push_back(pix_out);

         if (pix_out.eof) begin
            restart_frame();
         end else begin
            out_col++;
            if (out_col >= w) begin
               out_col = 0;
               out_row++;
            end
         end
      endfunction

      task report_mismatch(input string what);
         mismatch_count++;
         $display("MISMATCH at %0t: %s", $time, what);
      endtask

      // Compares one accepted result with the oldest pixel owed.
      task check_rgb(input logic [PIX_W-1:0] red, input logic [PIX_W-1:0] green,
                     input logic [PIX_W-1:0] blue, input logic eof);
         rgb_pixel_type want;
         if (pending_rgb.size() == 0) begin
            report_mismatch("result arrived with no pixel expected");
            return;
         end
         want = pending_rgb.pop_front();
         if (red !== want.red)
            report_mismatch($sformatf("red got %0d want %0d", red, want.red));
         if (green !== want.green)
            report_mismatch($sformatf("green got %0d want %0d", green, want.green));
         if (blue !== want.blue)
            report_mismatch($sformatf("blue got %0d want %0d", blue, want.blue));
         if (eof !== want.eof)
            report_mismatch($sformatf("end_of_frame got %0b want %0b", eof, want.eof));
      endtask
   endclass

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_ready;
   logic [PIX_W-1:0]       req_raw_pixel    = '0;
   logic                   req_flush        = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready        = 1'b0;
   logic [PIX_W-1:0]       rsp_red;
   logic [PIX_W-1:0]       rsp_green;
   logic [PIX_W-1:0]       rsp_blue;
   logic                   rsp_end_of_frame;
   logic                   csr_valid        = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index        = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata        = '0;

   demosaic_predictor rgb_model;
   bit          idle_on      = 1'b1;
   int unsigned stream_items = 0;
   int unsigned frame_w      = FRAME_WIDTH_RESET;
   int unsigned frame_h      = FRAME_HEIGHT_RESET;
   int unsigned holds_asked  = 0;
   int unsigned holds_served = 0;
   int unsigned hold_left    = 0;
   int unsigned ready_gap    = 0;

   bayer_bilinear_demosaic_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_raw_pixel    (req_raw_pixel),
      .req_flush        (req_flush),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_end_of_frame (rsp_end_of_frame),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // 4 ns clock.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Receiver: short random stalls, plus a long hold whenever one is asked for.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (holds_asked != holds_served) begin
         rsp_ready    <= 1'b0;
         hold_left    <= LONG_HOLD;
         holds_served <= holds_served + 1;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (ready_gap != 0) begin
         rsp_ready <= 1'b0;
         ready_gap <= ready_gap - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_ready <= 1'b0;
         ready_gap <= $urandom_range(0, 4);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Every transaction on the three channels goes to the predictor.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) rgb_model.write_register(csr_index, csr_wdata);
         if (req_valid && req_ready) rgb_model.take_sample(req_raw_pixel, req_flush);
         if (rsp_valid && rsp_ready)
            rgb_model.check_rgb(rsp_red, rsp_green, rsp_blue, rsp_end_of_frame);
      end
   end

   // Offers one input transaction, after an occasional random gap, and waits until it is taken.
   task automatic send_item(input logic [PIX_W-1:0] pixel, input logic flush);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_raw_pixel <= pixel;
      req_flush     <= flush;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Lets the block drain completely, then writes the chosen registers.
   task automatic reconfigure(input bit set_w, input logic [CSR_DATA_W-1:0] w_val,
                              input bit set_h, input logic [CSR_DATA_W-1:0] h_val);
      req_valid <= 1'b0;
      while (rgb_model.pending_rgb.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (set_w) begin
         csr_write(CSR_FRAME_WIDTH, w_val);
         frame_w = rgb_model.clamp_width(w_val[CFG_WIDTH_W-1:0]);
      end
      if (set_h) begin
         csr_write(CSR_FRAME_HEIGHT, h_val);
         frame_h = rgb_model.clamp_height(h_val);
      end
      csr_valid <= 1'b0;
   endtask

   // Sends one frame in raster order, with ignored flushes sprinkled in, then a tail
   // of flushes and discarded pixels to drain it.
   task automatic send_frame(input fill_kind_type fill, input int unsigned noise_pct,
                             input int unsigned tail_len);
      int unsigned      r, c, i;
      logic [PIX_W-1:0] pix;
      for (r = 0; r < frame_h; r++) begin
         for (c = 0; c < frame_w; c++) begin
            if ($urandom_range(0, 99) < noise_pct)
               send_item(PIX_W'($urandom_range(0, 255)), 1'b1);
            case (fill)
               FILL_ZERO:    pix = '0;
               FILL_MAX:     pix = '1;
               FILL_CHECKER: pix = ((r ^ c) & 1) ? '1 : '0;
               default:      pix = PIX_W'($urandom_range(0, 255));
            endcase
            send_item(pix, 1'b0);
            stream_items++;
         end
      end
      for (i = 0; i < tail_len; i++) begin
         send_item(PIX_W'($urandom_range(0, 255)),
                   (i == 0) ? 1'b1 : (i == 1) ? 1'b0 : 1'($urandom_range(0, 1)));
         stream_items++;
      end
   endtask

   // Stimulus sequence.
   initial begin
      int unsigned   n, kind, pick, random_start;
      bit            must_restart, set_w;
      logic [CSR_DATA_W-1:0] w_val, h_val;

      rgb_model = new();
      must_restart = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset defaults: a 640-wide frame, abandoned early in its second row.
      for (n = 0; n < 645; n++) send_item(PIX_W'($urandom_range(0, 255)), 1'b0);

      // Smallest frame: upper width bits ignored, width and height clamp up to 2.
      reconfigure(1'b1, 16'hE001, 1'b1, 16'h0001);
      send_frame(FILL_MAX, 40, frame_w + 1);
      send_frame(FILL_ZERO, 0, frame_w + 1);
      reconfigure(1'b1, 16'd3, 1'b1, 16'd3);
      send_frame(FILL_CHECKER, 10, frame_w + 1);

      // Widest row on the shortest frame; both values clamp, and the frame is cut short.
      reconfigure(1'b1, 16'hFFFF, 1'b1, 16'h0000);
      for (n = 0; n < 16; n++) send_item(PIX_W'($urandom_range(0, 255)), 1'b0);

      // Tallest frame, cut short by the next register write.
      reconfigure(1'b1, 16'd5, 1'b1, 16'hFFFF);
      for (n = 0; n < 17; n++) send_item(PIX_W'($urandom_range(0, 255)), 1'b0);

      // The receiver holds off while a whole frame is offered.
      reconfigure(1'b1, 16'd6, 1'b1, 16'd5);
      holds_asked++;
      send_frame(FILL_RANDOM, 0, frame_w + 1);

      // Random frames, mostly well formed; the last stretch runs without idling.
      random_start = stream_items;
      while (stream_items - random_start < RANDOM_ITEMS) begin
         idle_on = (stream_items - random_start < RANDOM_ITEMS - QUIET_ITEMS)
                   ? ($urandom_range(0, 3) != 0) : 1'b0;
         if (must_restart || $urandom_range(0, 2) == 0) begin
            pick  = $urandom_range(0, 9);
            w_val = (pick == 0) ? CSR_DATA_W'($urandom_range(0, 1)) :
                    (pick == 1) ? CSR_DATA_W'($urandom_range(13, 20)) :
                                  CSR_DATA_W'($urandom_range(2, 12));
            h_val = (pick == 2) ? CSR_DATA_W'($urandom_range(0, 1)) :
                                  CSR_DATA_W'($urandom_range(2, 6));
            set_w = $urandom_range(0, 3) != 0;
            reconfigure(set_w, w_val, !set_w || $urandom_range(0, 1), h_val);
            must_restart = 1'b0;
         end
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            // Partial frame, restarted by a register write.
            for (n = $urandom_range(1, frame_w * frame_h); n > 0; n--) begin
               send_item(PIX_W'($urandom_range(0, 255)), 1'b0);
               stream_items++;
            end
            must_restart = 1'b1;
         end else if (kind == 1) begin
            // Short tail: the next frame's first pixels drain this one.
            send_frame(FILL_RANDOM, 5, $urandom_range(0, frame_w));
         end else begin
            send_frame(FILL_RANDOM, 5, frame_w + 1);
         end
      end

      // Drain and let the pipeline settle before the verdict.
      req_valid <= 1'b0;
      while (rgb_model.pending_rgb.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (rgb_model.pending_rgb.size() != 0)
         rgb_model.report_mismatch($sformatf("%0d pixels never arrived",
                                             rgb_model.pending_rgb.size()));
      if (rgb_model.mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #3_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== sim.f =====
design/bbd_pkg.sv
design/bbd_line_store.sv
design/bbd_interp.sv
design/bayer_bilinear_demosaic_top.sv
dv/bayer_bilinear_demosaic_top_tb.sv
